// ----- hw/rtl/csba_pkg.sv -----
package csba_pkg;

  // widths of the request and response fields
  localparam int unsigned OP_W      = 1;
  localparam int unsigned CNT_FLD_W = 7;
  localparam int unsigned BASE_W    = 6;
  localparam int unsigned START_W   = 6;

  // widest map that the free path works on
  localparam int unsigned MAP_MAX_W = 64;

  // request operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // status of one window check
  typedef struct packed {
    logic fits;   // run lies inside the map
    logic clear;  // every slot in the run is free
  } csba_win_t;

endpackage

// ----- hw/rtl/csba_req_if.sv -----
interface csba_req_if;
  logic                             valid;
  logic                             ready;
  logic [csba_pkg::OP_W-1:0]        operation;
  logic [csba_pkg::CNT_FLD_W-1:0]   count;
  logic                             aligned;
  logic [csba_pkg::BASE_W-1:0]      free_base;

  modport source (output valid, operation, count, aligned, free_base, input ready);
  modport sink   (input valid, operation, count, aligned, free_base, output ready);
endinterface

// ----- hw/rtl/csba_rsp_if.sv -----
interface csba_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [csba_pkg::START_W-1:0]   start_slot;

  modport source (output valid, ok, start_slot, input ready);
  modport sink   (input valid, ok, start_slot, output ready);
endinterface

// ----- hw/rtl/csba_window_check.sv -----
module csba_window_check #(
  parameter int unsigned SLOTS = 64
) (
  input  logic [SLOTS-1:0]               map_i,
  input  logic [$clog2(SLOTS+1)-1:0]     cnt_i,
  input  logic [$clog2(SLOTS)+1:0]       off_i,
  output logic [SLOTS-1:0]               run_o,
  output csba_pkg::csba_win_t            stat_o
);
  import csba_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned SUM_W = IDX_W + 2;

  logic [SLOTS-1:0] base_mask;
  logic [SUM_W-1:0] run_end;

  // low cnt bits set; a full-width run shifts every one out
  assign base_mask = ~({SLOTS{1'b1}} << cnt_i);

  // run placed at the current offset
  assign run_o = base_mask << off_i[IDX_W-1:0];

  // end of run must stay inside the map
  assign run_end     = off_i + SUM_W'(cnt_i);
  assign stat_o.fits = (run_end <= SUM_W'(SLOTS));

  // overlap with used slots
  assign stat_o.clear = ((map_i & run_o) == '0);

endmodule

// ----- hw/rtl/contiguous_slot_bitmap_allocator.sv -----
// channel   | dir | handshake     | payload
// in_req    | in  | valid / ready | operation, count, aligned, free_base
// out_rsp   | out | valid / ready | ok, start_slot
//
// one request at a time; in_req.ready is high only while idle
// free, zero-count and oversize allocate: accept cycle, then response
// allocate: accept cycle, then one window check per cycle over offsets,
// up to SLOTS + 1 checks (the last one finds the run past the top)
// the response register holds until out_rsp.ready; no new request meanwhile
// rst_n (synchronous) empties the occupancy map and returns to idle
module contiguous_slot_bitmap_allocator #(
  parameter int unsigned SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  csba_req_if.sink      in_req,
  csba_rsp_if.source    out_rsp
);
  import csba_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS+1);
  localparam int unsigned SUM_W = IDX_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [SLOTS-1:0]     map_r, map_nxt;
  logic [SUM_W-1:0]     off_r, off_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     step_r, step_nxt;
  logic                 ok_r, ok_nxt;
  logic [START_W-1:0]   slot_r, slot_nxt;

  logic                 req_fire;
  logic [MAP_MAX_W-1:0] free_run;
  logic [SLOTS-1:0]     win_run;
  csba_win_t            win_stat;

  assign req_fire = in_req.valid && in_req.ready;

  // free run: all ones for count of 64 or more, bits past the top drop
  assign free_run = (in_req.count[CNT_FLD_W-1] ? {MAP_MAX_W{1'b1}}
                     : ~({MAP_MAX_W{1'b1}} << in_req.count[CNT_FLD_W-2:0]))
                    << in_req.free_base;

  // single window check unit, used by the scan
  csba_window_check #(
    .SLOTS (SLOTS)
  ) u_win (
    .map_i  (map_r),
    .cnt_i  (cnt_r),
    .off_i  (off_r),
    .run_o  (win_run),
    .stat_o (win_stat)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    map_nxt   = map_r;
    off_nxt   = off_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    ok_nxt    = ok_r;
    slot_nxt  = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req_fire) begin
          ok_nxt   = 1'b1;
          slot_nxt = '0;
          off_nxt  = '0;
          if (in_req.operation == OP_FREE) begin
            map_nxt   = map_r & ~free_run[SLOTS-1:0];
            state_nxt = ST_RESP;
          end else if (in_req.count == '0) begin
            state_nxt = ST_RESP;
          end else if (in_req.count > CNT_FLD_W'(SLOTS)) begin
            ok_nxt    = 1'b0;
            state_nxt = ST_RESP;
          end else begin
            cnt_nxt   = CNT_W'(in_req.count);
            step_nxt  = in_req.aligned ? CNT_W'(in_req.count) : CNT_W'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!win_stat.fits) begin
          ok_nxt    = 1'b0;
          slot_nxt  = '0;
          state_nxt = ST_RESP;
        end else if (win_stat.clear) begin
          map_nxt   = map_r | win_run;
          ok_nxt    = 1'b1;
          slot_nxt  = START_W'(off_r[IDX_W-1:0]);
          state_nxt = ST_RESP;
        end else begin
          off_nxt = off_r + SUM_W'(step_r);
        end
      end
      ST_RESP: begin
        if (out_rsp.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      map_r   <= '0;
    end else begin
      state_r <= state_nxt;
      map_r   <= map_nxt;
    end
  end

  // scan and response payload
  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    cnt_r  <= cnt_nxt;
    step_r <= step_nxt;
    ok_r   <= ok_nxt;
    slot_r <= slot_nxt;
  end

  // ports
  assign in_req.ready       = (state_r == ST_IDLE);
  assign out_rsp.valid      = (state_r == ST_RESP);
  assign out_rsp.ok         = ok_r;
  assign out_rsp.start_slot = slot_r;

endmodule

// ----- hw/rtl/csba_checker.sv -----
module csba_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_ok,
  input logic [csba_pkg::START_W-1:0]  out_start_slot
);
  import csba_pkg::*;

  // stalled response holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_start_slot))
    else $error("stalled response changed");

  // failure reports slot zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_start_slot == '0)
    else $error("failed allocate with nonzero slot");

  // busy after a request is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // no new request while a response waits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready while response pending");

  // reset leaves no response pending
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response after reset");

endmodule

bind contiguous_slot_bitmap_allocator csba_checker u_csba_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_ok         (out_rsp.ok),
  .out_start_slot (out_rsp.start_slot)
);

// ----- dv/tb_contiguous_slot_bitmap_allocator.sv -----
module tb_contiguous_slot_bitmap_allocator;
  import csba_pkg::*;

  localparam int unsigned NUM_SLOTS   = 64;
  localparam int unsigned RAND_ITEMS  = 1250;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          TAIL_CYCLES = NUM_SLOTS + 16;
  localparam int          MAX_SHOWN   = 10;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [CNT_FLD_W-1:0] count;
    logic                 aligned;
    logic [BASE_W-1:0]    free_base;
  } slot_req_t;

  typedef struct packed {
    logic               ok;
    logic [START_W-1:0] start_slot;
  } slot_rsp_t;

  typedef struct {
    slot_req_t req;
    int        gap;
    bit        drain;
  } stim_t;

  logic clk;
  logic rst_n;

  csba_req_if req_if ();
  csba_rsp_if rsp_if ();

  contiguous_slot_bitmap_allocator #(
    .SLOTS(NUM_SLOTS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  // predictor state and bookkeeping
  logic [MAP_MAX_W-1:0] slot_map;
  stim_t                req_queue[$];
  slot_rsp_t            pending_rsp[$];
  int                   issued;
  int                   accepted;
  int                   rsp_seen;
  int                   rsp_handled;
  int                   gap_left;
  int                   stall_left;
  int                   err_count;
  int                   cycle_count;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // low n bits set, all ones for 64 and up
  function automatic logic [MAP_MAX_W-1:0] span_mask(input logic [CNT_FLD_W-1:0] n);
    if (n >= MAP_MAX_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // first-fit allocate or free on the shadow map
  function automatic slot_rsp_t predict_slot_rsp(input slot_req_t r);
    slot_rsp_t            res;
    logic [MAP_MAX_W-1:0] run;
    int unsigned          stride;
    int unsigned          off;
    logic                 found;
    res   = '0;
    found = 1'b0;
    if (r.operation == OP_FREE) begin
      run      = span_mask(r.count) << r.free_base;
      slot_map = slot_map & ~run;
      res.ok   = 1'b1;
    end else if (r.count == 0) begin
      res.ok = 1'b1;
    end else begin
      stride = r.aligned ? r.count : 1;
      for (off = 0; off + r.count <= NUM_SLOTS; off += stride) begin
        run = span_mask(r.count) << off;
        if (!found && ((slot_map & run) == '0)) begin
          slot_map       = slot_map | run;
          res.ok         = 1'b1;
          res.start_slot = off[START_W-1:0];
          found          = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_req(input logic [OP_W-1:0] op, input int cnt, input logic al,
                          input int base, input bit drain);
    stim_t s;
    s.req.operation = op;
    s.req.count     = cnt[CNT_FLD_W-1:0];
    s.req.aligned   = al;
    s.req.free_base = base[BASE_W-1:0];
    // every 250 requests open with a back-to-back stretch
    s.gap           = (req_queue.size() % 250 < 50) ? 0 : pick_gap();
    s.drain         = drain;
    req_queue.push_back(s);
  endtask

  // request driver, falling edge
  always @(negedge clk) begin
    logic nxt_valid;
    stim_t nxt;
    if (rst_n) begin
      nxt_valid = req_if.valid;
      if (req_if.valid && accepted == issued) nxt_valid = 1'b0;
      if (!nxt_valid && req_queue.size() > 0) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (!req_queue[0].drain || (pending_rsp.size() == 0 && accepted == issued)) begin
          nxt = req_queue.pop_front();
          req_if.operation <= nxt.req.operation;
          req_if.count     <= nxt.req.count;
          req_if.aligned   <= nxt.req.aligned;
          req_if.free_base <= nxt.req.free_base;
          nxt_valid = 1'b1;
          issued    = issued + 1;
          gap_left  = (req_queue.size() > 0) ? req_queue[0].gap : 0;
        end
      end
      req_if.valid <= nxt_valid;
    end
  end

  // response ready with random stalls, falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (rsp_seen != rsp_handled) begin
        rsp_handled = rsp_seen;
        stall_left  = pick_gap();
      end else if (stall_left == 0 && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      // quiet window with no stalls at all
      if (cycle_count % 3000 < 600) stall_left = 0;
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // monitor: check responses, then predict newly accepted requests
  always @(posedge clk) begin
    slot_rsp_t got;
    slot_rsp_t exp_rsp;
    slot_req_t taken;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_seen       = rsp_seen + 1;
        got.ok         = rsp_if.ok;
        got.start_slot = rsp_if.start_slot;
        if (pending_rsp.size() == 0) begin
          err_count = err_count + 1;
          if (err_count <= MAX_SHOWN)
            $display("unexpected response: ok=%0d start_slot=%0d", got.ok, got.start_slot);
        end else begin
          exp_rsp = pending_rsp.pop_front();
          if (got.ok !== exp_rsp.ok || got.start_slot !== exp_rsp.start_slot) begin
            err_count = err_count + 1;
            if (err_count <= MAX_SHOWN)
              $display({"response mismatch: expected ok=%0d start_slot=%0d, ",
                        "got ok=%0d start_slot=%0d"},
                       exp_rsp.ok, exp_rsp.start_slot, got.ok, got.start_slot);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        taken.operation = req_if.operation;
        taken.count     = req_if.count;
        taken.aligned   = req_if.aligned;
        taken.free_base = req_if.free_base;
        accepted        = accepted + 1;
        pending_rsp.push_back(predict_slot_rsp(taken));
      end
    end
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("contiguous_slot_bitmap_allocator test failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int  i;
    int  r;
    int  c;
    logic [OP_W-1:0] op;
    int  cnt;
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_ALLOC;
    req_if.count     = '0;
    req_if.aligned   = 1'b0;
    req_if.free_base = '0;
    rsp_if.ready     = 1'b0;
    slot_map         = '0;
    issued           = 0;
    accepted         = 0;
    rsp_seen         = 0;
    rsp_handled      = 0;
    gap_left         = 0;
    stall_left       = 0;
    err_count        = 0;
    cycle_count      = 0;

    // directed: zero counts, alignment, oversize, full map, top edge, fragmentation
    push_req(OP_ALLOC, 0,   1'b0, 63, 0);
    push_req(OP_ALLOC, 0,   1'b1, 0,  0);
    push_req(OP_ALLOC, 1,   1'b0, 0,  0);
    push_req(OP_ALLOC, 3,   1'b1, 0,  0);
    push_req(OP_ALLOC, 2,   1'b0, 0,  0);
    push_req(OP_ALLOC, 65,  1'b0, 0,  0);
    push_req(OP_ALLOC, 127, 1'b1, 63, 0);
    push_req(OP_FREE,  64,  1'b0, 0,  0);
    push_req(OP_ALLOC, 64,  1'b1, 0,  0);
    push_req(OP_ALLOC, 1,   1'b0, 0,  0);
    push_req(OP_FREE,  127, 1'b1, 63, 0);
    push_req(OP_ALLOC, 1,   1'b1, 0,  0);
    push_req(OP_FREE,  10,  1'b0, 60, 0);
    push_req(OP_FREE,  10,  1'b0, 60, 0);
    push_req(OP_FREE,  0,   1'b0, 5,  0);
    push_req(OP_ALLOC, 4,   1'b1, 0,  0);
    push_req(OP_FREE,  64,  1'b0, 0,  1);
    push_req(OP_ALLOC, 64,  1'b0, 0,  0);
    push_req(OP_FREE,  1,   1'b0, 10, 0);
    push_req(OP_FREE,  1,   1'b0, 20, 0);
    push_req(OP_ALLOC, 2,   1'b0, 0,  0);
    push_req(OP_ALLOC, 2,   1'b1, 0,  0);
    push_req(OP_ALLOC, 1,   1'b1, 0,  0);
    push_req(OP_FREE,  64,  1'b1, 0,  1);

    // random: mostly small allocations against frees, so the map fragments
    for (i = 0; i < RAND_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      c = $urandom_range(0, 99);
      if (r < 58) begin
        op = OP_ALLOC;
        if (c < 70)      cnt = $urandom_range(1, 8);
        else if (c < 90) cnt = $urandom_range(9, 32);
        else if (c < 97) cnt = $urandom_range(33, 64);
        else if (c < 98) cnt = 0;
        else             cnt = $urandom_range(65, 127);
      end else if (r < 96) begin
        op = OP_FREE;
        if (c < 75)      cnt = $urandom_range(1, 12);
        else if (c < 90) cnt = $urandom_range(13, 63);
        else if (c < 93) cnt = 0;
        else             cnt = $urandom_range(64, 127);
      end else begin
        op  = OP_FREE;
        cnt = 64;
      end
      if (r >= 96)
        push_req(op, cnt, 1'($urandom_range(0, 1)), 0, (i % 300 == 299));
      else
        push_req(op, cnt, 1'($urandom_range(0, 1)), $urandom_range(0, 63),
                 (i % 300 == 299));
    end

    // reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (req_queue.size() > 0 || accepted != issued || req_if.valid) @(posedge clk);
    while (pending_rsp.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0 && pending_rsp.size() == 0) begin
      $display("contiguous_slot_bitmap_allocator test passed");
    end else begin
      $display("contiguous_slot_bitmap_allocator test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/csba_pkg.sv
hw/rtl/csba_req_if.sv
hw/rtl/csba_rsp_if.sv
hw/rtl/csba_window_check.sv
hw/rtl/contiguous_slot_bitmap_allocator.sv
hw/rtl/csba_checker.sv
dv/tb_contiguous_slot_bitmap_allocator.sv
